// ===== sv/matrix_multiply_and_power_macros.svh =====
// assertion helpers used by the checker file
`ifndef MATRIX_MULTIPLY_AND_POWER_MACROS_SVH
`define MATRIX_MULTIPLY_AND_POWER_MACROS_SVH

// property checked only outside reset
`define MMP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("mmp check failed");

// property checked at every edge, reset included
`define MMP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("mmp check failed");

`endif

// ===== sv/mmp_pkg.sv =====
package mmp_pkg;

    // index field width covering the whole parameter range (1 to 8)
    localparam int IDX_W = 3;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_MUL    = 2'd2;
    localparam logic [1:0] CMD_POW    = 2'd3;

    localparam logic [1:0] REG_ROWS_A     = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_COLS_B     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
        logic [31:0]        exponent;
    } in_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } out_t;

    typedef enum logic [1:0] {
        SRC_A = 2'd0,
        SRC_B = 2'd1,
        SRC_R = 2'd2,
        SRC_S = 2'd3
    } src_t;

    // control shared by all cells
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic ld_y;
        logic init_pw;
        logic commit;
        logic dst_s;
        src_t x_src;
        src_t y_src;
    } ctrl_t;

    // one element of an x row walking down the chain
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] k;
        logic [31:0]      x;
    } tok_t;

endpackage

// ===== sv/mmp_cell.sv =====
module mmp_cell #(
    parameter int MAX_DIM = 4,
    parameter int COL = 0,
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mmp_pkg::ctrl_t ctrl,
    input  logic [IW-1:0] wr_row,
    input  logic [IW-1:0] wr_col,
    input  logic [31:0]   wr_val,
    input  logic [IW-1:0] rd_row,
    input  mmp_pkg::tok_t tok_in,
    output mmp_pkg::tok_t tok_out,
    output logic [31:0]   x_out
);
    import mmp_pkg::*;

    // column COL of every matrix
    logic [31:0] a_mem [MAX_DIM];
    logic [31:0] b_mem [MAX_DIM];
    logic [31:0] r_mem [MAX_DIM];
    logic [31:0] s_mem [MAX_DIM];
    logic [31:0] t_mem [MAX_DIM];
    logic [31:0] y_mem [MAX_DIM];

    tok_t          tok_reg;
    logic          p_vld_reg;
    logic          p_first_reg;
    logic          p_last_reg;
    logic [IW-1:0] p_i_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   acc_sum;
    logic [31:0]   y_rd;
    logic          col_hit;

    assign tok_out = tok_reg;
    assign y_rd    = y_mem[tok_reg.k[IW-1:0]];
    assign acc_sum = (p_first_reg ? 32'd0 : acc_reg) + prod_reg;
    assign col_hit = (wr_col == IW'(COL));

    always_comb begin
        case (ctrl.x_src)
            SRC_A:   x_out = a_mem[rd_row];
            SRC_B:   x_out = b_mem[rd_row];
            SRC_R:   x_out = r_mem[rd_row];
            SRC_S:   x_out = s_mem[rd_row];
            default: x_out = a_mem[rd_row];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            p_vld_reg <= 1'b0;
        end else begin
            tok_reg   <= tok_in;
            p_vld_reg <= tok_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= tok_reg.x * y_rd;
        p_first_reg <= tok_reg.first;
        p_last_reg  <= tok_reg.last;
        p_i_reg     <= tok_reg.i[IW-1:0];
        if (p_vld_reg) begin
            acc_reg <= acc_sum;
            if (p_last_reg) begin
                t_mem[p_i_reg] <= acc_sum;
            end
        end
        if (ctrl.wr_a && col_hit) begin
            a_mem[wr_row] <= wr_val;
        end
        if (ctrl.wr_b && col_hit) begin
            b_mem[wr_row] <= wr_val;
        end
        if (ctrl.ld_y) begin
            case (ctrl.y_src)
                SRC_A:   y_mem <= a_mem;
                SRC_B:   y_mem <= b_mem;
                SRC_R:   y_mem <= r_mem;
                SRC_S:   y_mem <= s_mem;
                default: y_mem <= b_mem;
            endcase
        end
        if (ctrl.init_pw) begin
            r_mem <= a_mem;
            s_mem <= a_mem;
        end else if (ctrl.commit) begin
            if (ctrl.dst_s) begin
                s_mem <= t_mem;
            end else begin
                r_mem <= t_mem;
            end
        end
    end

endmodule

// ===== sv/matrix_multiply_and_power.sv =====
// matrix multiply and matrix power engine
// - load A or B one element per transaction on s_ (cmd 0 / 1), one per cycle
//   while idle, no result; indices at or beyond MAX_DIM are dropped
// - cmd 2 streams A*B, cmd 3 streams A^exponent (square of size rows_a),
//   row-major on m_, last marks the final element; exponent 0 or 1 gives A
// - dimensions come from the APB registers rows_a, inner_size, cols_b
//   (0 acts as 1, above MAX_DIM acts as MAX_DIM); write them only when idle
// - math runs on a chain of MAX_DIM column cells: while feeding, one x element
//   enters the chain per cycle and each cell does one multiply-accumulate per cycle
// - the length of a matrix product is set by the single entry point of the
//   chain; a power does one init step plus up to two products per bit of
//   exponent-1
// - output then gives one element per cycle while m_ready is high; a stalled
//   receiver holds the element in the output register and stops the stream
// - s_ready is low from a compute transaction until its last element is
//   loaded into the output register
// - reset (aresetn low, synchronous) returns to idle and sets all three
//   dimensions to 4; matrix contents are not cleared
module matrix_multiply_and_power #(
    parameter int MAX_DIM = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input transactions
    input  logic          s_valid,
    output logic          s_ready,
    input  mmp_pkg::in_t  s_data,
    // result transactions
    output logic          m_valid,
    input  logic          m_ready,
    output mmp_pkg::out_t m_data,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mmp_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_LOADY = 7'b0000100,
        ST_FEED  = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_SPARE = 7'b1000000
    } state_t;

    // which product the chain is working on
    typedef enum logic [1:0] {
        MK_PROD = 2'd0,
        MK_RS   = 2'd1,
        MK_SS   = 2'd2
    } mul_t;

    function automatic int clamp_dim(logic [2:0] d);
        if (d == 3'd0) begin
            return 1;
        end
        if (int'(d) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(d);
    endfunction

    // configuration registers
    logic [2:0] rows_a_reg;
    logic [2:0] inner_reg;
    logic [2:0] cols_b_reg;
    logic       cfg_wr;

    state_t        state_reg, state_next;
    mul_t          mk_reg, mk_next;
    logic          pow_reg, pow_next;
    logic [31:0]   exp_reg, exp_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] oi_reg, oi_next;
    logic [IW-1:0] oj_reg, oj_next;
    logic          endp1_reg, endp2_reg;
    logic          m_valid_reg, m_valid_next;
    out_t          out_reg, out_next;

    logic [CW-1:0] n_c, m_c, p_c;
    logic [IW-1:0] n_lim, m_lim, p_lim, k_lim, col_lim;
    logic          in_range;
    logic          end_hit;
    logic [31:0]   exp_half;

    ctrl_t         ctrl;
    logic [IW-1:0] rd_row;
    tok_t          feed_tok;
    tok_t          chain [MAX_DIM+1];
    logic [31:0]   xo [MAX_DIM];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= 3'd4;
            inner_reg  <= 3'd4;
            cols_b_reg <= 3'd4;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS_A:     rows_a_reg <= pwdata[2:0];
                REG_INNER_SIZE: inner_reg  <= pwdata[2:0];
                REG_COLS_B:     cols_b_reg <= pwdata[2:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A:     prdata = {29'd0, rows_a_reg};
            REG_INNER_SIZE: prdata = {29'd0, inner_reg};
            REG_COLS_B:     prdata = {29'd0, cols_b_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- effective dimensions ----------------
    assign n_c     = CW'(clamp_dim(rows_a_reg));
    assign m_c     = CW'(clamp_dim(inner_reg));
    assign p_c     = CW'(clamp_dim(cols_b_reg));
    assign n_lim   = IW'(n_c - CW'(1));
    assign m_lim   = IW'(m_c - CW'(1));
    assign p_lim   = IW'(p_c - CW'(1));
    assign k_lim   = (mk_reg == MK_PROD) ? m_lim : n_lim;
    assign col_lim = pow_reg ? n_lim : p_lim;

    assign in_range = (int'(s_data.row) < MAX_DIM) && (int'(s_data.col) < MAX_DIM);
    assign exp_half = exp_reg >> 1;

    // last element of the last row has left the final cell
    assign end_hit = chain[MAX_DIM].vld && chain[MAX_DIM].last &&
                     (chain[MAX_DIM].i[IW-1:0] == n_lim);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign chain[0] = feed_tok;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        mk_next      = mk_reg;
        pow_next     = pow_reg;
        exp_next     = exp_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        oi_next      = oi_reg;
        oj_next      = oj_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        ctrl       = '0;
        ctrl.x_src = (mk_reg == MK_PROD) ? SRC_A : ((mk_reg == MK_RS) ? SRC_R : SRC_S);
        ctrl.y_src = (mk_reg == MK_PROD) ? SRC_B : SRC_S;
        ctrl.dst_s = (mk_reg == MK_SS);
        rd_row     = i_reg;
        feed_tok   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.cmd)
                        CMD_LOAD_A: ctrl.wr_a = in_range;
                        CMD_LOAD_B: ctrl.wr_b = in_range;
                        CMD_MUL: begin
                            mk_next    = MK_PROD;
                            pow_next   = 1'b0;
                            state_next = ST_LOADY;
                        end
                        CMD_POW: begin
                            pow_next   = 1'b1;
                            exp_next   = (s_data.exponent == 32'd0) ? 32'd0 :
                                         s_data.exponent - 32'd1;
                            state_next = ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                // running result and squared base both start as A
                ctrl.init_pw = 1'b1;
                if (exp_reg == 32'd0) begin
                    oi_next    = '0;
                    oj_next    = '0;
                    state_next = ST_EMIT;
                end else begin
                    mk_next    = exp_reg[0] ? MK_RS : MK_SS;
                    state_next = ST_LOADY;
                end
            end
            ST_LOADY: begin
                // snapshot y operand columns so the destination may alias it
                ctrl.ld_y  = 1'b1;
                i_next     = '0;
                k_next     = '0;
                state_next = ST_FEED;
            end
            ST_FEED: begin
                feed_tok.vld   = 1'b1;
                feed_tok.first = (k_reg == '0);
                feed_tok.last  = (k_reg == k_lim);
                feed_tok.i     = IDX_W'(i_reg);
                feed_tok.k     = IDX_W'(k_reg);
                feed_tok.x     = xo[k_reg];
                if (k_reg == k_lim) begin
                    k_next = '0;
                    if (i_reg == n_lim) begin
                        state_next = ST_DRAIN;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (endp2_reg) begin
                    ctrl.commit = 1'b1;
                    oi_next     = '0;
                    oj_next     = '0;
                    case (mk_reg)
                        MK_PROD: state_next = ST_EMIT;
                        MK_RS: begin
                            mk_next    = MK_SS;
                            state_next = ST_LOADY;
                        end
                        default: begin
                            exp_next = exp_half;
                            if (exp_half == 32'd0) begin
                                state_next = ST_EMIT;
                            end else begin
                                mk_next    = exp_half[0] ? MK_RS : MK_SS;
                                state_next = ST_LOADY;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                ctrl.x_src = SRC_R;
                rd_row     = oi_reg;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    out_next.out_row   = 2'(oi_reg);
                    out_next.out_col   = 2'(oj_reg);
                    out_next.out_value = xo[oj_reg];
                    out_next.last      = (oi_reg == n_lim) && (oj_reg == col_lim);
                    if (oj_reg == col_lim) begin
                        oj_next = '0;
                        if (oi_reg == n_lim) begin
                            state_next = ST_IDLE;
                        end else begin
                            oi_next = oi_reg + IW'(1);
                        end
                    end else begin
                        oj_next = oj_reg + IW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            endp1_reg   <= 1'b0;
            endp2_reg   <= 1'b0;
            exp_reg     <= 32'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            endp1_reg   <= end_hit;
            endp2_reg   <= endp1_reg;
            exp_reg     <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        mk_reg  <= mk_next;
        pow_reg <= pow_next;
        i_reg   <= i_next;
        k_reg   <= k_next;
        oi_reg  <= oi_next;
        oj_reg  <= oj_next;
        out_reg <= out_next;
    end

    // ---------------- cell chain, one cell per column ----------------
    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        mmp_cell #(
            .MAX_DIM (MAX_DIM),
            .COL     (c)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .wr_row  (IW'(s_data.row)),
            .wr_col  (IW'(s_data.col)),
            .wr_val  (s_data.value),
            .rd_row  (rd_row),
            .tok_in  (chain[c]),
            .tok_out (chain[c+1]),
            .x_out   (xo[c])
        );
    end

endmodule

// ===== sv/mmp_checker.sv =====
`include "matrix_multiply_and_power_macros.svh"

module mmp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input mmp_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input mmp_pkg::out_t m_data
);
    import mmp_pkg::*;

    // a stalled result holds its value
    `MMP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // no result is shown right after reset
    `MMP_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid)

    // a compute transaction makes the block busy in the next cycle
    `MMP_ASSERT(a_busy, aclk, aresetn,
        s_valid && s_ready && (s_data.cmd == CMD_MUL || s_data.cmd == CMD_POW) |=> !s_ready)

endmodule

bind matrix_multiply_and_power mmp_checker u_mmp_checker (.*);

// ===== sim/matrix_multiply_and_power_tb.sv =====
`timescale 1ns / 1ps

module matrix_multiply_and_power_tb;
    import mmp_pkg::*;

    localparam int MAX_DIM = 4;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int CYCLE_LIMIT = 1500000;
    // registers sit at 4*index on the configuration port
    localparam logic [3:0] ADDR_ROWS_A     = 4'(4 * REG_ROWS_A);
    localparam logic [3:0] ADDR_INNER_SIZE = 4'(4 * REG_INNER_SIZE);
    localparam logic [3:0] ADDR_COLS_B     = 4'(4 * REG_COLS_B);

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    matrix_multiply_and_power #(.MAX_DIM(MAX_DIM)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // predictor state: own copy of matrices and dimension registers
    logic [31:0] mat_a [CELLS];
    logic [31:0] mat_b [CELLS];
    logic [2:0] dim_rows;
    logic [2:0] dim_inner;
    logic [2:0] dim_cols;

    out_t expected_elems[$];
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int eff_dim(logic [2:0] d);
        if (d == 3'd0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(d);
    endfunction

    typedef logic [31:0] grid_t [CELLS];

    // wrapped product of x (n by m) and y (m by p), row-major with MAX_DIM stride
    function automatic grid_t grid_mul(grid_t x, grid_t y, int n, int m, int p);
        grid_t z;
        logic [31:0] acc;
        for (int i = 0; i < CELLS; i++) begin
            z[i] = '0;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < p; j++) begin
                acc = '0;
                for (int k = 0; k < m; k++) begin
                    acc += x[i * MAX_DIM + k] * y[k * MAX_DIM + j];
                end
                z[i * MAX_DIM + j] = acc;
            end
        end
        return z;
    endfunction

    // updates the matrices or queues the elements a transaction produces
    task automatic predict_matrix_op(in_t t);
        grid_t ga;
        grid_t gb;
        grid_t res;
        grid_t base;
        logic [31:0] rem;
        int n;
        int m;
        int p;
        out_t o;
        n = eff_dim(dim_rows);
        m = eff_dim(dim_inner);
        p = eff_dim(dim_cols);
        if (t.cmd == CMD_LOAD_A) begin
            mat_a[t.row * MAX_DIM + t.col] = t.value;
            return;
        end
        if (t.cmd == CMD_LOAD_B) begin
            mat_b[t.row * MAX_DIM + t.col] = t.value;
            return;
        end
        ga = mat_a;
        gb = mat_b;
        if (t.cmd == CMD_MUL) begin
            res = grid_mul(ga, gb, n, m, p);
        end else begin
            res = ga;
            base = ga;
            p = n;
            rem = (t.exponent == 0) ? 32'd0 : t.exponent - 1;
            while (rem != 0) begin
                if (rem[0]) begin
                    res = grid_mul(res, base, n, n, n);
                end
                base = grid_mul(base, base, n, n, n);
                rem = rem >> 1;
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < p; j++) begin
                o.out_row = 2'(i);
                o.out_col = 2'(j);
                o.out_value = res[i * MAX_DIM + j];
                o.last = (i == n - 1) && (j == p - 1);
                expected_elems.insert(expected_elems.size(), o);
            end
        end
    endtask

    // every result transaction is compared against the oldest expectation
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_elems.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, m_data);
                fail_count++;
            end else begin
                if (m_data !== expected_elems[0]) begin
                    $display("%0t mismatch: expected %p actual %p",
                             $time, expected_elems[0], m_data);
                    fail_count++;
                end
                void'(expected_elems.pop_front());
            end
        end
    end

    // receiver stall, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // runaway guard
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // send one transaction: random idle, then hold valid until accepted;
    // valid stays up afterwards so the next transaction can follow directly
    task automatic send_item(in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_matrix_op(t);
    endtask

    // only called while idle: drain, let the chain settle, then write
    task automatic write_dim(logic [3:0] addr, logic [31:0] val);
        s_valid <= 1'b0;
        while (expected_elems.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_ROWS_A:     dim_rows = val[2:0];
            ADDR_INNER_SIZE: dim_inner = val[2:0];
            default:         dim_cols = val[2:0];
        endcase
    endtask

    function automatic in_t make_item(logic [1:0] c, logic [1:0] r, logic [1:0] k,
                                      logic [31:0] v, logic [31:0] e);
        in_t t;
        t.cmd = c;
        t.row = r;
        t.col = k;
        t.value = v;
        t.exponent = e;
        return t;
    endfunction

    // fill all of A and B so no read ever hits an unwritten element
    task automatic fill_all(bit extreme);
        logic [31:0] v;
        for (int i = 0; i < CELLS; i++) begin
            v = extreme ? (($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000)
                        : ($urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(9)) - 4);
            send_item(make_item(CMD_LOAD_A, 2'(i / 4), 2'(i % 4), v, $urandom()));
            v = extreme ? 32'hffffffff : $urandom();
            send_item(make_item(CMD_LOAD_B, 2'(i / 4), 2'(i % 4), v, $urandom()));
        end
    endtask

    // directed rows: identity A, B extremes, then powers; an extreme fill, a product and a power follow
    in_t directed_rows [$];
    // results that can be read off directly: A identity, power gives identity
    initial begin
        in_t t;
        int phase_idle [4];
        int phase_stall [4];
        logic [1:0] c;
        phase_idle = '{0, 54, 0, 21};
        phase_stall = '{0, 0, 54, 21};
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        dim_rows = 3'd4;
        dim_inner = 3'd4;
        dim_cols = 3'd4;
        for (int i = 0; i < CELLS; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: A = identity, B = extremes, then powers
        for (int i = 0; i < CELLS; i++) begin
            directed_rows.insert(directed_rows.size(),
                                 make_item(CMD_LOAD_A, 2'(i / 4), 2'(i % 4),
                                           (i % 5 == 0) ? 32'd1 : 32'd0, 32'd0));
        end
        directed_rows.insert(directed_rows.size(),
                             make_item(CMD_LOAD_B, 2'd0, 2'd0, 32'h80000000, 32'd0));
        directed_rows.insert(directed_rows.size(),
                             make_item(CMD_LOAD_B, 2'd3, 2'd3, 32'h7fffffff, '1));
        directed_rows.insert(directed_rows.size(),
                             make_item(CMD_POW, 2'd3, 2'd3, '1, 32'd0));
        directed_rows.insert(directed_rows.size(),
                             make_item(CMD_POW, 2'd0, 2'd0, '0, 32'd1));
        directed_rows.insert(directed_rows.size(),
                             make_item(CMD_POW, 2'd0, 2'd0, '0, 32'hffffffff));
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
            // identity to any power is identity: check the typed-in answer too
            if (directed_rows[i].cmd == CMD_POW) begin
                for (int r = 0; r < 4; r++) begin
                    for (int k = 0; k < 4; k++) begin
                        if (expected_elems[expected_elems.size() - 16 + r * 4 + k].out_value
                            !== ((r == k) ? 32'd1 : 32'd0)) begin
                            $display("%0t mismatch: expected identity actual %p", $time,
                                     expected_elems[expected_elems.size() - 16 + r * 4 + k]);
                            fail_count++;
                        end
                    end
                end
            end
        end
        fill_all(1'b1);
        send_item(make_item(CMD_MUL, 2'd0, 2'd0, '0, '0));
        send_item(make_item(CMD_POW, 2'd1, 2'd2, '0, 32'd2));

        // random part: one phase per idling mode, each with new dimensions
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph % 4];
            recv_stall_pct = phase_stall[ph % 4];
            write_dim(ADDR_ROWS_A, (ph < 3) ? 32'(ph * 4) : 32'($urandom_range(7)) |
                      ($urandom() & 32'hfffffff8));
            write_dim(ADDR_INNER_SIZE, (ph < 3) ? 32'(ph * 7 % 8) : $urandom());
            write_dim(ADDR_COLS_B, (ph < 3) ? 32'(1 + ph) : $urandom());
            fill_all(ph == 3);
            for (int k = 0; k < 36; k++) begin
                c = 2'($urandom_range(3));
                t = make_item(c, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom(),
                              ($urandom_range(3) == 0) ? $urandom()
                                                       : 32'($urandom_range(6)));
                send_item(t);
            end
        end

        s_valid <= 1'b0;
        while (expected_elems.size() != 0) begin
            @(posedge aclk);
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== matrix_multiply_and_power.f =====
+incdir+sv
sv/mmp_pkg.sv
sv/mmp_cell.sv
sv/matrix_multiply_and_power.sv
sv/mmp_checker.sv
sim/matrix_multiply_and_power_tb.sv
